>>> hdl/ucs_pkg.sv
// ucs_pkg: types, constants and helpers for the urgency/cherish scheduler.
// No dependencies.
package ucs_pkg;

    localparam int QUEUE_COUNT_DEF = 4;
    localparam int LEVEL_COUNT_DEF = 4;
    localparam int FIFO_DEPTH_DEF  = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;
    localparam int MEM_ADDR_W = 16;
    localparam logic [8:0] PROB_ONE = 9'd256;

    typedef enum logic [2:0] {
        CMD_INS_IN   = 3'd0,
        CMD_INS_OUT  = 3'd1,
        CMD_DROP_IN  = 3'd2,
        CMD_DROP_OUT = 3'd3,
        CMD_NEXT_IN  = 3'd4,
        CMD_NEXT_OUT = 3'd5,
        CMD_IN_PROB  = 3'd6,
        CMD_OUT_PROB = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        REG_URGENCY_MAP = 3'd0,
        REG_SKIP_PROB   = 3'd1,
        REG_DROP_PROB   = 3'd2,
        REG_CHERISH_TH  = 3'd3,
        REG_ABS_TH      = 3'd4,
        REG_IN_MAX_LEN  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  queue_id;
        logic [31:0] random_bytes;
    } in_item_t;

    typedef struct packed {
        logic [1:0] chosen_queue;
        logic       granted;
        logic       empty_error;
        logic       overflow_error;
        logic [8:0] drop_probability;
    } out_item_t;

    // memory access request from control to storage
    typedef struct packed {
        logic                  wr_en;
        logic [MEM_ADDR_W-1:0] wr_addr;
        logic [1:0]            wr_data;
        logic                  rd_en;
        logic [MEM_ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

>>> hdl/ucs_fifo_mem.sv
// ucs_fifo_mem: single memory holding the input FIFO and all level FIFOs.
// Depends on ucs_pkg.
module ucs_fifo_mem
    import ucs_pkg::*;
#(
    parameter int ADDR_W = 8
)
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [1:0]        rd_data
);

    logic [1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[ADDR_W-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr[ADDR_W-1:0]];
        end
    end

endmodule

>>> hdl/urgency_cherish_scheduler.sv
// urgency_cherish_scheduler: top level, command control, pointers and config.
// Depends on ucs_pkg and ucs_fifo_mem.
//
//  channel | handshake       | payload
//  in      | in_valid/in_stall   | in_item_t
//  out     | out_valid/out_stall | out_item_t
//  cfg     | cfg_we              | cfg_index, cfg_data
//
// A command is accepted in the idle state only; in_stall is high while one is in flight.
// The execute state decides and issues the FIFO memory access; the output state loads
// the output register with the registered read data and raises out_valid, after which
// the next command can be accepted in idle. A stalled output register holds the command
// in flight in its load step. No clearing pass after reset.
module urgency_cherish_scheduler
    import ucs_pkg::*;
#(
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
    parameter int LEVEL_COUNT = LEVEL_COUNT_DEF,
    parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = PW + 1;
    localparam int LW = $clog2(LEVEL_COUNT);
    localparam int QW = $clog2(QUEUE_COUNT);
    localparam int AW = $clog2(FIFO_DEPTH * (LEVEL_COUNT + 1));
    localparam int OCW = $clog2(FIFO_DEPTH * LEVEL_COUNT + 1);

    logic [7:0]  urg_map_reg;
    logic [35:0] skip_reg, dropp_reg, cher_reg, abs_reg;
    logic [6:0]  max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            urg_map_reg <= '0;
            skip_reg    <= '0;
            dropp_reg   <= 36'd34426978560;
            cher_reg    <= '0;
            abs_reg     <= '0;
            max_len_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_URGENCY_MAP: urg_map_reg <= cfg_data[7:0];
                REG_SKIP_PROB:   skip_reg    <= cfg_data;
                REG_DROP_PROB:   dropp_reg   <= cfg_data;
                REG_CHERISH_TH:  cher_reg    <= cfg_data;
                REG_ABS_TH:      abs_reg     <= cfg_data;
                REG_IN_MAX_LEN:  max_len_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    function automatic logic [8:0] fld9(input logic [35:0] r, input int idx);
        logic [8:0] v;
        v = '0;
        if (idx < 4)
        begin
            v = r[idx*9 +: 9];
        end
        return v;
    endfunction

    state_t state_reg, state_next;
    in_item_t cmd_reg;
    logic [PW-1:0] in_head_reg, in_head_next;
    logic [CW-1:0] in_cnt_reg, in_cnt_next;
    logic [PW-1:0] lhead_reg [LEVEL_COUNT];
    logic [PW-1:0] lhead_next [LEVEL_COUNT];
    logic [CW-1:0] lcnt_reg [LEVEL_COUNT];
    logic [CW-1:0] lcnt_next [LEVEL_COUNT];
    logic [OCW-1:0] ocnt_reg, ocnt_next;
    logic [LW-1:0] last_u_reg, last_u_next;
    out_item_t res_reg, res_next;
    out_item_t out_reg;
    out_item_t out_load;
    logic out_valid_reg;
    mem_req_t req;
    logic [1:0] rd_data;

    ucs_fifo_mem #(.ADDR_W(AW)) u_mem (.clk(clk), .req(req), .rd_data(rd_data));

    logic out_free;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic [QW-1:0] q;
    logic [LW-1:0] u, sel_lv;
    logic [1:0] urg_raw;
    logic sel_found, any_ne;
    logic [8:0] th, ab;
    logic [CW-1:0] in_sum, lv_sum;
    logic [PW-1:0] in_tail, lv_tail;

    always_comb
    begin
        q = QW'((32'(cmd_reg.queue_id) >= QUEUE_COUNT)
            ? 32'(cmd_reg.queue_id) - QUEUE_COUNT : 32'(cmd_reg.queue_id));
        urg_raw = urg_map_reg[2*q +: 2];
        u = (32'(urg_raw) >= LEVEL_COUNT) ? LW'(LEVEL_COUNT - 1) : LW'(urg_raw);
        in_sum = CW'(in_head_reg) + in_cnt_reg;
        in_tail = (in_sum >= CW'(FIFO_DEPTH)) ? PW'(in_sum - CW'(FIFO_DEPTH)) : PW'(in_sum);
        lv_sum = CW'(lhead_reg[u]) + lcnt_reg[u];
        lv_tail = (lv_sum >= CW'(FIFO_DEPTH)) ? PW'(lv_sum - CW'(FIFO_DEPTH)) : PW'(lv_sum);
        sel_found = 1'b0;
        any_ne = 1'b0;
        sel_lv = '0;
        for (int k = LEVEL_COUNT - 1; k >= 0; k--)
        begin
            if (lcnt_reg[k] != '0 && !sel_found)
            begin
                any_ne = 1'b1;
                sel_lv = LW'(k);
                if (!(fld9(skip_reg, k) > {1'b0, cmd_reg.random_bytes[(k%4)*8 +: 8]}))
                begin
                    sel_found = 1'b1;
                end
            end
        end
        th = fld9(cher_reg, int'(q));
        ab = fld9(abs_reg, int'(q));
        if (ab < th) ab = th;
    end

    always_comb
    begin
        in_head_next = in_head_reg;
        in_cnt_next  = in_cnt_reg;
        lhead_next   = lhead_reg;
        lcnt_next    = lcnt_reg;
        ocnt_next    = ocnt_reg;
        last_u_next  = last_u_reg;
        res_next     = res_reg;
        req          = '0;
        if (state_reg == ST_EXEC)
        begin
            res_next = '0;
            case (cmd_t'(cmd_reg.command))
                CMD_INS_IN:
                begin
                    if (in_cnt_reg >= CW'(FIFO_DEPTH))
                        res_next.overflow_error = 1'b1;
                    else
                    begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = MEM_ADDR_W'(in_tail);
                        req.wr_data = 2'(q);
                        in_cnt_next = in_cnt_reg + 1'b1;
                    end
                end
                CMD_INS_OUT:
                begin
                    if (lcnt_reg[u] >= CW'(FIFO_DEPTH))
                        res_next.overflow_error = 1'b1;
                    else
                    begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = MEM_ADDR_W'((AW'(u) + AW'(1)) * AW'(FIFO_DEPTH)
                            + AW'(lv_tail));
                        req.wr_data = 2'(q);
                        lcnt_next[u] = lcnt_reg[u] + 1'b1;
                        ocnt_next = ocnt_reg + 1'b1;
                        last_u_next = u;
                    end
                end
                CMD_DROP_IN:
                    if (in_cnt_reg != '0) in_cnt_next = in_cnt_reg - 1'b1;
                CMD_DROP_OUT:
                    if (lcnt_reg[last_u_reg] != '0)
                    begin
                        lcnt_next[last_u_reg] = lcnt_reg[last_u_reg] - 1'b1;
                        if (ocnt_reg != '0) ocnt_next = ocnt_reg - 1'b1;
                    end
                CMD_NEXT_IN:
                    if (in_cnt_reg != '0)
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = MEM_ADDR_W'(in_head_reg);
                        in_head_next = (in_head_reg == PW'(FIFO_DEPTH - 1)) ? '0
                            : in_head_reg + 1'b1;
                        in_cnt_next = in_cnt_reg - 1'b1;
                        res_next.granted = 1'b1;
                    end
                CMD_NEXT_OUT:
                    if (any_ne)
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = MEM_ADDR_W'((AW'(sel_lv) + AW'(1)) * AW'(FIFO_DEPTH)
                            + AW'(lhead_reg[sel_lv]));
                        lhead_next[sel_lv] = (lhead_reg[sel_lv] == PW'(FIFO_DEPTH - 1)) ? '0
                            : lhead_reg[sel_lv] + 1'b1;
                        lcnt_next[sel_lv] = lcnt_reg[sel_lv] - 1'b1;
                        if (ocnt_reg != '0) ocnt_next = ocnt_reg - 1'b1;
                        res_next.granted = 1'b1;
                    end
                    else
                        res_next.empty_error = 1'b1;
                CMD_IN_PROB:
                    res_next.drop_probability =
                        (32'(in_cnt_reg) < 32'(max_len_reg)) ? 9'd0 : PROB_ONE;
                default:
                begin
                    if (32'(ocnt_reg) < 32'(th))
                        res_next.drop_probability = 9'd0;
                    else if (32'(ocnt_reg) < 32'(ab))
                        res_next.drop_probability =
                            (fld9(dropp_reg, int'(q)) > PROB_ONE) ? PROB_ONE
                                : fld9(dropp_reg, int'(q));
                    else
                        res_next.drop_probability = PROB_ONE;
                end
            endcase
        end
    end

    always_comb
    begin
        out_load = res_reg;
        if (res_reg.granted)
            out_load.chosen_queue = rd_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_head_reg   <= '0;
            in_cnt_reg    <= '0;
            ocnt_reg      <= '0;
            last_u_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < LEVEL_COUNT; k++)
            begin
                lhead_reg[k] <= '0;
                lcnt_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            in_head_reg <= in_head_next;
            in_cnt_reg  <= in_cnt_next;
            lhead_reg   <= lhead_next;
            lcnt_reg    <= lcnt_next;
            ocnt_reg    <= ocnt_next;
            last_u_reg  <= last_u_next;
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
            cmd_reg <= in_item;
        res_reg <= res_next;
        if (state_reg == ST_OUT && out_free)
            out_reg <= out_load;
    end

endmodule

>>> tb/testbench.sv
// Testbench for urgency_cherish_scheduler: table-driven directed commands, then random
// command streams checked against a behavioral scheduler model. Depends on ucs_pkg.
`timescale 1ns / 100ps
module testbench;
    import ucs_pkg::*;

    localparam int DEPTH = 64;
    localparam int EXP_DEPTH = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #5 clk = ~clk;

    urgency_cherish_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model state
    logic [7:0]  m_urg;
    logic [35:0] m_skip, m_drop, m_cher, m_abs;
    logic [6:0]  m_inmax;
    logic [1:0]  m_infifo [DEPTH];
    int          m_inhead, m_incnt;
    logic [1:0]  m_lvfifo [4][DEPTH];
    int          m_lvhead [4];
    int          m_lvcnt [4];
    int          m_outcnt;
    int          m_last;

    out_item_t exp_buf [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_hold = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch #%0d: %s got %0d expected %0d", n_checked, what, got, want);
        errors++;
    endtask

    function automatic logic [1:0] pop_level(input int lv);
        logic [1:0] v;
        v = m_lvfifo[lv][m_lvhead[lv]];
        m_lvhead[lv] = (m_lvhead[lv] + 1) % DEPTH;
        m_lvcnt[lv]--;
        if (m_outcnt > 0) m_outcnt--;
        return v;
    endfunction

    function automatic out_item_t schedule_cmd(input in_item_t it);
        out_item_t r;
        int u, lowest, th, ab, p, b;
        r = '0;
        case (cmd_t'(it.command))
            CMD_INS_IN:
                if (m_incnt >= DEPTH) r.overflow_error = 1'b1;
                else
                begin
                    m_infifo[(m_inhead + m_incnt) % DEPTH] = it.queue_id;
                    m_incnt++;
                end
            CMD_INS_OUT:
            begin
                u = int'(m_urg[2*it.queue_id +: 2]);
                if (m_lvcnt[u] >= DEPTH) r.overflow_error = 1'b1;
                else
                begin
                    m_lvfifo[u][(m_lvhead[u] + m_lvcnt[u]) % DEPTH] = it.queue_id;
                    m_lvcnt[u]++;
                    m_outcnt++;
                    m_last = u;
                end
            end
            CMD_DROP_IN:
                if (m_incnt > 0) m_incnt--;
            CMD_DROP_OUT:
                if (m_lvcnt[m_last] > 0)
                begin
                    m_lvcnt[m_last]--;
                    if (m_outcnt > 0) m_outcnt--;
                end
            CMD_NEXT_IN:
                if (m_incnt > 0)
                begin
                    r.chosen_queue = m_infifo[m_inhead];
                    m_inhead = (m_inhead + 1) % DEPTH;
                    m_incnt--;
                    r.granted = 1'b1;
                end
            CMD_NEXT_OUT:
            begin
                lowest = -1;
                for (int k = 3; k >= 0; k--)
                begin
                    if (!r.granted && m_lvcnt[k] != 0)
                    begin
                        lowest = k;
                        p = int'(m_skip[9*k +: 9]);
                        b = int'(it.random_bytes[8*k +: 8]);
                        if (!(p > b))
                        begin
                            r.chosen_queue = pop_level(k);
                            r.granted = 1'b1;
                        end
                    end
                end
                if (!r.granted)
                begin
                    if (lowest >= 0)
                    begin
                        r.chosen_queue = pop_level(lowest);
                        r.granted = 1'b1;
                    end
                    else r.empty_error = 1'b1;
                end
            end
            CMD_IN_PROB:
                r.drop_probability = (m_incnt < m_inmax) ? 9'd0 : PROB_ONE;
            default:
            begin
                th = int'(m_cher[9*it.queue_id +: 9]);
                ab = int'(m_abs[9*it.queue_id +: 9]);
                if (ab < th) ab = th;
                p = int'(m_drop[9*it.queue_id +: 9]);
                if (m_outcnt < th) r.drop_probability = 9'd0;
                else if (m_outcnt < ab) r.drop_probability = (p > 256) ? PROB_ONE : p[8:0];
                else r.drop_probability = PROB_ONE;
            end
        endcase
        return r;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [35:0] val);
        in_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_URGENCY_MAP: m_urg = val[7:0];
            REG_SKIP_PROB:   m_skip = val;
            REG_DROP_PROB:   m_drop = val;
            REG_CHERISH_TH:  m_cher = val;
            REG_ABS_TH:      m_abs = val;
            default:         m_inmax = val[6:0];
        endcase
    endtask

    // one transaction; expectation stored on acceptance
    task automatic send_cmd(input in_item_t it, input bit has_want, input out_item_t want);
        out_item_t pred;
        cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pred = schedule_cmd(it);
        if (has_want && pred != want)
            report_mismatch("directed row against model", n_sent, n_sent);
        exp_buf[exp_wr % EXP_DEPTH] = pred;
        exp_wr++;
        n_sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        cfg_we <= 1'b0;
        while (exp_wr != exp_rd) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_wr == exp_rd)
                report_mismatch("unexpected result transaction", 1, 0);
            else
            begin
                out_item_t w;
                w = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (out_item.chosen_queue != w.chosen_queue)
                    report_mismatch("chosen_queue", int'(out_item.chosen_queue),
                                    int'(w.chosen_queue));
                if (out_item.granted != w.granted)
                    report_mismatch("granted", int'(out_item.granted), int'(w.granted));
                if (out_item.empty_error != w.empty_error)
                    report_mismatch("empty_error", int'(out_item.empty_error),
                                    int'(w.empty_error));
                if (out_item.overflow_error != w.overflow_error)
                    report_mismatch("overflow_error", int'(out_item.overflow_error),
                                    int'(w.overflow_error));
                if (out_item.drop_probability != w.drop_probability)
                    report_mismatch("drop_probability", int'(out_item.drop_probability),
                                    int'(w.drop_probability));
                n_checked++;
            end
        end
        out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end

    typedef struct {
        cmd_t        c;
        logic [1:0]  q;
        logic [31:0] rnd;
        bit          known;
        out_item_t   want;
    } row_t;

    function automatic out_item_t mk(input int cq, input int g, input int ee,
                                     input int ov, input int pr);
        out_item_t r;
        r.chosen_queue = 2'(cq); r.granted = 1'(g); r.empty_error = 1'(ee);
        r.overflow_error = 1'(ov); r.drop_probability = 9'(pr);
        return r;
    endfunction

    function automatic in_item_t rand_item(input int mode);
        in_item_t it;
        int r;
        it.queue_id = 2'($urandom_range(3));
        it.random_bytes = $urandom;
        r = $urandom_range(99);
        if (mode == 0)
            it.command = (r < 30) ? CMD_INS_OUT : (r < 50) ? CMD_NEXT_OUT :
                         (r < 62) ? CMD_INS_IN : (r < 72) ? CMD_NEXT_IN :
                         3'($urandom_range(7));
        else
            it.command = (r < 45) ? CMD_INS_OUT : (r < 70) ? CMD_INS_IN :
                         3'($urandom_range(7));
        return it;
    endfunction

    initial
    begin
        row_t rows [17];
        int cnt;
        m_urg = '0; m_skip = '0; m_drop = 36'd34426978560; m_cher = '0; m_abs = '0;
        m_inmax = 7'd64; m_inhead = 0; m_incnt = 0; m_outcnt = 0; m_last = 0;
        for (int k = 0; k < 4; k++) begin m_lvhead[k] = 0; m_lvcnt[k] = 0; end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; after reset everything is empty
        rows[0]  = '{CMD_NEXT_IN, 2'd0, 32'h0, 1, mk(0, 0, 0, 0, 0)};
        rows[1]  = '{CMD_NEXT_OUT, 2'd3, 32'hFFFFFFFF, 1, mk(0, 0, 1, 0, 0)};
        rows[2]  = '{CMD_DROP_IN, 2'd0, 32'h0, 1, mk(0, 0, 0, 0, 0)};
        rows[3]  = '{CMD_DROP_OUT, 2'd0, 32'h0, 1, mk(0, 0, 0, 0, 0)};
        rows[4]  = '{CMD_IN_PROB, 2'd0, 32'h0, 1, mk(0, 0, 0, 0, 0)};
        rows[5]  = '{CMD_OUT_PROB, 2'd3, 32'h0, 1, mk(0, 0, 0, 0, 256)};
        rows[6]  = '{CMD_INS_IN, 2'd3, 32'h0, 0, '0};
        rows[7]  = '{CMD_INS_IN, 2'd1, 32'hFFFFFFFF, 0, '0};
        rows[8]  = '{CMD_NEXT_IN, 2'd0, 32'h0, 1, mk(3, 1, 0, 0, 0)};
        rows[9]  = '{CMD_DROP_IN, 2'd0, 32'h0, 0, '0};
        rows[10] = '{CMD_NEXT_IN, 2'd0, 32'h0, 1, mk(0, 0, 0, 0, 0)};
        rows[11] = '{CMD_INS_OUT, 2'd2, 32'h0, 0, '0};
        rows[12] = '{CMD_INS_OUT, 2'd1, 32'h0, 0, '0};
        rows[13] = '{CMD_OUT_PROB, 2'd1, 32'h0, 0, '0};
        rows[14] = '{CMD_DROP_OUT, 2'd0, 32'h0, 0, '0};
        rows[15] = '{CMD_NEXT_OUT, 2'd0, 32'h0, 1, mk(2, 1, 0, 0, 0)};
        rows[16] = '{CMD_NEXT_OUT, 2'd0, 32'h0, 1, mk(0, 0, 1, 0, 0)};
        foreach (rows[i]) send_cmd('{rows[i].c, rows[i].q, rows[i].rnd}, rows[i].known,
                                   rows[i].want);
        wait_drain();

        // full FIFOs: overflow on insert, then in_prob at max length
        write_reg(REG_IN_MAX_LEN, 36'd0);
        send_cmd('{CMD_IN_PROB, 2'd0, 32'h0}, 1, mk(0, 0, 0, 0, 256));
        wait_drain();
        write_reg(REG_IN_MAX_LEN, 36'd64);
        write_reg(REG_URGENCY_MAP, 36'hE4);
        for (int i = 0; i < DEPTH; i++) send_cmd('{CMD_INS_IN, 2'(i), 32'h0}, 0, '0);
        send_cmd('{CMD_INS_IN, 2'd0, 32'h0}, 1, mk(0, 0, 0, 1, 0));
        send_cmd('{CMD_IN_PROB, 2'd0, 32'h0}, 1, mk(0, 0, 0, 0, 256));
        for (int i = 0; i < DEPTH + 1; i++) send_cmd('{CMD_INS_OUT, 2'd3, $urandom}, 0, '0);
        // receiver holds off while the sender keeps offering
        recv_hold = 1'b1;
        fork
            begin repeat (300) @(posedge clk); recv_hold = 1'b0; end
            for (int i = 0; i < 40; i++) send_cmd(rand_item(0), 0, '0);
        join
        wait_drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 23; recv_idle_pct = 66; end
                2: begin send_idle_pct = 66; recv_idle_pct = 23; end
                4: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                default: ;
            endcase
            write_reg(REG_URGENCY_MAP, (ph == 5) ? 36'hFF : 36'($urandom_range(255)));
            write_reg(REG_SKIP_PROB, (ph == 1) ? 36'hFFFFFFFFF : (ph == 3) ? 36'h0 :
                      {4'($urandom), 32'($urandom)});
            write_reg(REG_DROP_PROB, (ph == 2) ? 36'hFFFFFFFFF :
                      {4'($urandom), 32'($urandom)});
            cnt = $urandom_range(12);
            write_reg(REG_CHERISH_TH, {4{9'(cnt)}} ^ 36'($urandom_range(3)));
            write_reg(REG_ABS_TH, (ph == 4) ? 36'h0 : {4{9'(cnt + $urandom_range(40))}});
            write_reg(REG_IN_MAX_LEN, (ph == 0) ? 36'd127 : 36'($urandom_range(64)));
            for (int i = 0; i < 120; i++)
                send_cmd(rand_item((i / 30) % 2), 0, '0);
            if (ph == 3) wait_drain();
            wait_drain();
        end

        $display("ran %0d commands, %0d results checked, six register settings", n_sent,
                 n_checked);
        $display("covered overflow, empty pops, skip extremes and output back-pressure");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> urgency_cherish_scheduler.f
hdl/ucs_pkg.sv
hdl/ucs_fifo_mem.sv
hdl/urgency_cherish_scheduler.sv
tb/testbench.sv
